@@ src/dmnc_pkg.sv @@
// Shared types, constants and helpers of the directory MESI node controller.
// Used by every module of the block; depends on nothing.
package dmnc_pkg;

  localparam int NUM_NODES   = 4;
  localparam int CACHE_LINES = 4;
  localparam int MEM_BLOCKS  = 16;
  localparam int MAX_MSGS    = 5;

  localparam logic [7:0] NO_TAG    = 8'hFF;
  localparam logic [7:0] MEM_STEP  = 8'd20;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MSG   = 2'd2;

  localparam logic [3:0] MT_READ_REQUEST  = 4'd0;
  localparam logic [3:0] MT_WRITE_REQUEST = 4'd1;
  localparam logic [3:0] MT_REPLY_RD      = 4'd2;
  localparam logic [3:0] MT_REPLY_WR      = 4'd3;
  localparam logic [3:0] MT_REPLY_ID      = 4'd4;
  localparam logic [3:0] MT_INV           = 4'd5;
  localparam logic [3:0] MT_UPGRADE       = 4'd6;
  localparam logic [3:0] MT_WRITEBACK_INV = 4'd7;
  localparam logic [3:0] MT_WRITEBACK_INT = 4'd8;
  localparam logic [3:0] MT_FLUSH         = 4'd9;
  localparam logic [3:0] MT_FLUSH_INVACK  = 4'd10;
  localparam logic [3:0] MT_EVICT_SHARED  = 4'd11;
  localparam logic [3:0] MT_EVICT_MOD     = 4'd12;

  localparam logic [1:0] LS_M = 2'd0;
  localparam logic [1:0] LS_E = 2'd1;
  localparam logic [1:0] LS_S = 2'd2;
  localparam logic [1:0] LS_I = 2'd3;

  localparam logic [1:0] DS_EM = 2'd0;
  localparam logic [1:0] DS_S  = 2'd1;
  localparam logic [1:0] DS_U  = 2'd2;

  localparam logic signed [2:0] NO_NODE = -3'sd1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_READ,
    KIND_WRITE,
    KIND_MSG
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         msg_type;
    logic [1:0]         sender;
    logic [5:0]         addr;
    logic [7:0]         value;
    logic [3:0]         mask;
    logic signed [2:0]  second;
    logic [1:0]         hs;
  } item_t;

  typedef struct packed {
    logic [1:0]        dest;
    logic [3:0]        mtype;
    logic [5:0]        addr;
    logic [7:0]        value;
    logic [3:0]        sharers;
    logic signed [2:0] second;
    logic [1:0]        hs;
  } msg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_EMIT
  } bstate_t;

  function automatic msg_t make_msg(logic [1:0] dest, logic [3:0] mtype, logic [5:0] addr,
                                    logic [7:0] value, logic [3:0] sharers,
                                    logic signed [2:0] second, logic [1:0] hs);
    msg_t m;
    m.dest    = dest;
    m.mtype   = mtype;
    m.addr    = addr;
    m.value   = value;
    m.sharers = sharers;
    m.second  = second;
    m.hs      = hs;
    return m;
  endfunction

  function automatic logic [1:0] lowest_bit(logic [3:0] m);
    logic [1:0] r;
    r = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (m[i]) r = 2'(i);
    end
    return r;
  endfunction

endpackage

@@ src/dmnc_front.sv @@
// Front end: takes requests, classifies them and queues them for the back end.
// Depends on dmnc_pkg. Requests that cause nothing are dropped here.
module dmnc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [3:0]        in_msg_type,
  input  logic [1:0]        in_msg_sender,
  input  logic [5:0]        in_block_address,
  input  logic [7:0]        in_data_value,
  input  logic [3:0]        in_sharer_mask,
  input  logic signed [2:0] in_second_node,
  input  logic [1:0]        in_home_state,
  output logic              q_valid,
  input  logic              q_ready,
  output dmnc_pkg::item_t   q_item
);

  dmnc_pkg::item_t queue_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  dmnc_pkg::item_t item;
  logic            push, pop;

  always_comb begin
    item.msg_type = in_msg_type;
    item.sender   = in_msg_sender;
    item.addr     = in_block_address;
    item.value    = in_data_value;
    item.mask     = in_sharer_mask;
    item.second   = in_second_node;
    item.hs       = in_home_state;
    unique case (in_operation)
      dmnc_pkg::OP_READ:  item.kind = dmnc_pkg::KIND_READ;
      dmnc_pkg::OP_WRITE: item.kind = dmnc_pkg::KIND_WRITE;
      dmnc_pkg::OP_MSG:
        item.kind = (in_msg_type <= dmnc_pkg::MT_EVICT_MOD) ? dmnc_pkg::KIND_MSG
                                                            : dmnc_pkg::KIND_NONE;
      default: item.kind = dmnc_pkg::KIND_NONE;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready && (item.kind != dmnc_pkg::KIND_NONE);
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue_r[wr_ptr_r] <= item;
  end

endmodule

@@ src/dmnc_back.sv @@
// Back end: holds cache, home memory and directory, runs one request at a time
// and sends the resulting messages one per cycle while out_ready is high. Depends on dmnc_pkg.
module dmnc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              q_valid,
  output logic              q_ready,
  input  dmnc_pkg::item_t   q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output dmnc_pkg::msg_t    out_msg,
  output logic              out_last
);

  dmnc_pkg::bstate_t state_r, state_nxt;
  dmnc_pkg::item_t   cur_r;
  logic [1:0]        node_id_r;
  logic [7:0]        line_tag_r  [dmnc_pkg::CACHE_LINES];
  logic [7:0]        line_data_r [dmnc_pkg::CACHE_LINES];
  logic [1:0]        line_st_r   [dmnc_pkg::CACHE_LINES];
  logic [7:0]        mem_r       [dmnc_pkg::MEM_BLOCKS];
  logic [3:0]        dsh_r       [dmnc_pkg::MEM_BLOCKS];
  logic [1:0]        dst_r       [dmnc_pkg::MEM_BLOCKS];
  logic              await_r, await_nxt;
  logic [7:0]        pend_r, pend_nxt;
  dmnc_pkg::msg_t    msgs_r [dmnc_pkg::MAX_MSGS];
  dmnc_pkg::msg_t    msgs_nxt [dmnc_pkg::MAX_MSGS];
  logic [2:0]        cnt_r, cnt_nxt;
  logic [2:0]        idx_r;

  // Execute-stage datapath signals.
  logic [1:0]        ci;
  logic [3:0]        blk;
  logic [1:0]        home;
  logic [7:0]        c_tag, c_data;
  logic [1:0]        c_st;
  logic [3:0]        c_sh, sh_clr;
  logic [1:0]        c_ds;
  logic [7:0]        c_mem;
  logic              hit, is_home, is_req, sec_ok, evictable, tag_eq;
  logic [3:0]        sbit, rbit;
  logic [7:0]        ln_tag, ln_data;
  logic [1:0]        ln_st;
  logic [3:0]        n_sh;
  logic [1:0]        n_ds;
  logic [7:0]        n_mem;
  logic [2:0]        n;
  dmnc_pkg::msg_t    ev_msg;
  logic              exec_en, out_fire;

  assign ci      = cur_r.addr[1:0];
  assign blk     = cur_r.addr[3:0];
  assign home    = cur_r.addr[5:4];
  assign c_tag   = line_tag_r[ci];
  assign c_data  = line_data_r[ci];
  assign c_st    = line_st_r[ci];
  assign c_sh    = dsh_r[blk];
  assign c_ds    = dst_r[blk];
  assign c_mem   = mem_r[blk];
  assign tag_eq  = (c_tag == {2'b00, cur_r.addr});
  assign hit     = tag_eq && (c_st != dmnc_pkg::LS_I);
  assign is_home = (home == node_id_r);
  assign sec_ok  = !cur_r.second[2];
  assign is_req  = sec_ok && (cur_r.second[1:0] == node_id_r);
  assign sbit    = 4'b0001 << cur_r.sender;
  assign rbit    = sec_ok ? (4'b0001 << cur_r.second[1:0]) : 4'b0000;
  assign sh_clr  = c_sh & ~sbit;
  assign evictable = (c_tag != dmnc_pkg::NO_TAG) && (c_st != dmnc_pkg::LS_I);
  assign ev_msg  = (c_st == dmnc_pkg::LS_M)
    ? dmnc_pkg::make_msg(c_tag[5:4], dmnc_pkg::MT_EVICT_MOD, c_tag[5:0], c_data, 4'd0,
                         dmnc_pkg::NO_NODE, dmnc_pkg::DS_U)
    : dmnc_pkg::make_msg(c_tag[5:4], dmnc_pkg::MT_EVICT_SHARED, c_tag[5:0], 8'd0, 4'd0,
                         dmnc_pkg::NO_NODE, dmnc_pkg::DS_U);

  always_comb begin
    for (int i = 0; i < dmnc_pkg::MAX_MSGS; i++) msgs_nxt[i] = '0;
    n         = 3'd0;
    ln_tag    = c_tag;
    ln_data   = c_data;
    ln_st     = c_st;
    n_sh      = c_sh;
    n_ds      = c_ds;
    n_mem     = c_mem;
    await_nxt = await_r;
    pend_nxt  = pend_r;
    case (cur_r.kind)
      dmnc_pkg::KIND_READ: begin
        if (!await_r && !hit) begin
          msgs_nxt[0] = dmnc_pkg::make_msg(home, dmnc_pkg::MT_READ_REQUEST, cur_r.addr, 8'd0,
                                           4'd0, dmnc_pkg::NO_NODE, dmnc_pkg::DS_U);
          n = 3'd1;
          await_nxt = 1'b1;
        end
      end
      dmnc_pkg::KIND_WRITE: begin
        if (!await_r) begin
          if (hit && (c_st == dmnc_pkg::LS_M || c_st == dmnc_pkg::LS_E)) begin
            ln_data = cur_r.value;
            ln_st   = dmnc_pkg::LS_M;
          end else begin
            if (hit) begin
              msgs_nxt[0] = dmnc_pkg::make_msg(home, dmnc_pkg::MT_UPGRADE, cur_r.addr, 8'd0,
                                               4'd0, dmnc_pkg::NO_NODE, dmnc_pkg::DS_S);
            end else begin
              msgs_nxt[0] = dmnc_pkg::make_msg(home, dmnc_pkg::MT_WRITE_REQUEST, cur_r.addr,
                                               cur_r.value, 4'd0, dmnc_pkg::NO_NODE,
                                               dmnc_pkg::DS_U);
            end
            n = 3'd1;
            pend_nxt  = cur_r.value;
            await_nxt = 1'b1;
          end
        end
      end
      dmnc_pkg::KIND_MSG: begin
        unique case (cur_r.msg_type)
          dmnc_pkg::MT_READ_REQUEST, dmnc_pkg::MT_WRITE_REQUEST: begin
            if (is_home) begin
              n = 3'd1;
              if (c_ds == dmnc_pkg::DS_EM && c_sh != 4'd0) begin
                msgs_nxt[0] = dmnc_pkg::make_msg(dmnc_pkg::lowest_bit(c_sh),
                  (cur_r.msg_type == dmnc_pkg::MT_READ_REQUEST) ? dmnc_pkg::MT_WRITEBACK_INT
                                                                : dmnc_pkg::MT_WRITEBACK_INV,
                  cur_r.addr, 8'd0, 4'd0, $signed({1'b0, cur_r.sender}), dmnc_pkg::DS_EM);
              end else if (cur_r.msg_type == dmnc_pkg::MT_READ_REQUEST) begin
                if (c_ds == dmnc_pkg::DS_S) begin
                  n_sh = c_sh | sbit;
                  msgs_nxt[0] = dmnc_pkg::make_msg(cur_r.sender, dmnc_pkg::MT_REPLY_RD,
                    cur_r.addr, c_mem, 4'd0, dmnc_pkg::NO_NODE, dmnc_pkg::DS_S);
                end else begin
                  n_sh = sbit;
                  n_ds = dmnc_pkg::DS_EM;
                  msgs_nxt[0] = dmnc_pkg::make_msg(cur_r.sender, dmnc_pkg::MT_REPLY_RD,
                    cur_r.addr, c_mem, 4'd0, dmnc_pkg::NO_NODE, dmnc_pkg::DS_EM);
                end
              end else begin
                n_mem = cur_r.value;
                if (c_ds == dmnc_pkg::DS_S) begin
                  msgs_nxt[0] = dmnc_pkg::make_msg(cur_r.sender, dmnc_pkg::MT_REPLY_ID,
                    cur_r.addr, 8'd0, c_sh, dmnc_pkg::NO_NODE, dmnc_pkg::DS_EM);
                end else begin
                  msgs_nxt[0] = dmnc_pkg::make_msg(cur_r.sender, dmnc_pkg::MT_REPLY_WR,
                    cur_r.addr, cur_r.value, 4'd0, dmnc_pkg::NO_NODE, dmnc_pkg::DS_EM);
                end
                n_sh = sbit;
                n_ds = dmnc_pkg::DS_EM;
              end
            end
          end
          dmnc_pkg::MT_REPLY_RD, dmnc_pkg::MT_REPLY_WR: begin
            if (evictable) begin
              msgs_nxt[0] = ev_msg;
              n = 3'd1;
            end
            ln_tag  = {2'b00, cur_r.addr};
            ln_data = cur_r.value;
            if (cur_r.msg_type == dmnc_pkg::MT_REPLY_WR) ln_st = dmnc_pkg::LS_M;
            else ln_st = (cur_r.hs == dmnc_pkg::DS_EM) ? dmnc_pkg::LS_E : dmnc_pkg::LS_S;
            await_nxt = 1'b0;
          end
          dmnc_pkg::MT_REPLY_ID: begin
            for (int i = 0; i < dmnc_pkg::NUM_NODES; i++) begin
              if (cur_r.mask[i]) begin
                msgs_nxt[n] = dmnc_pkg::make_msg(2'(i), dmnc_pkg::MT_INV, cur_r.addr, 8'd0,
                                                 4'd0, dmnc_pkg::NO_NODE, dmnc_pkg::DS_U);
                n = n + 3'd1;
              end
            end
            if (!hit) begin
              if (evictable) begin
                msgs_nxt[n] = ev_msg;
                n = n + 3'd1;
              end
              ln_tag = {2'b00, cur_r.addr};
            end
            ln_st     = dmnc_pkg::LS_M;
            ln_data   = pend_r;
            await_nxt = 1'b0;
          end
          dmnc_pkg::MT_INV: begin
            if (tag_eq) ln_st = dmnc_pkg::LS_I;
          end
          dmnc_pkg::MT_UPGRADE: begin
            if (is_home && c_ds == dmnc_pkg::DS_S) begin
              msgs_nxt[0] = dmnc_pkg::make_msg(cur_r.sender, dmnc_pkg::MT_REPLY_ID, cur_r.addr,
                8'd0, sh_clr, dmnc_pkg::NO_NODE, dmnc_pkg::DS_EM);
              n    = 3'd1;
              n_sh = sbit;
              n_ds = dmnc_pkg::DS_EM;
            end
          end
          dmnc_pkg::MT_WRITEBACK_INV, dmnc_pkg::MT_WRITEBACK_INT: begin
            if (tag_eq && (c_st == dmnc_pkg::LS_M || c_st == dmnc_pkg::LS_E)) begin
              msgs_nxt[0] = dmnc_pkg::make_msg(home,
                (cur_r.msg_type == dmnc_pkg::MT_WRITEBACK_INT) ? dmnc_pkg::MT_FLUSH
                                                               : dmnc_pkg::MT_FLUSH_INVACK,
                cur_r.addr, c_data, 4'd0, sec_ok ? cur_r.second : dmnc_pkg::NO_NODE,
                dmnc_pkg::DS_EM);
              n = 3'd1;
              if (sec_ok && cur_r.second[1:0] != home) begin
                msgs_nxt[1] = msgs_nxt[0];
                msgs_nxt[1].dest = cur_r.second[1:0];
                n = 3'd2;
              end
              ln_st = (cur_r.msg_type == dmnc_pkg::MT_WRITEBACK_INT) ? dmnc_pkg::LS_S
                                                                     : dmnc_pkg::LS_I;
            end
          end
          dmnc_pkg::MT_FLUSH, dmnc_pkg::MT_FLUSH_INVACK: begin
            if (is_home) begin
              n_mem = cur_r.value;
              if (cur_r.msg_type == dmnc_pkg::MT_FLUSH) begin
                n_sh = sbit | rbit;
                n_ds = dmnc_pkg::DS_S;
              end else begin
                n_sh = rbit;
                n_ds = dmnc_pkg::DS_EM;
              end
            end
            if (is_req) begin
              if (evictable) begin
                msgs_nxt[0] = ev_msg;
                n = 3'd1;
              end
              ln_tag = {2'b00, cur_r.addr};
              if (cur_r.msg_type == dmnc_pkg::MT_FLUSH) begin
                ln_data = cur_r.value;
                ln_st   = dmnc_pkg::LS_S;
              end else begin
                ln_data = pend_r;
                ln_st   = dmnc_pkg::LS_M;
              end
              await_nxt = 1'b0;
            end
          end
          dmnc_pkg::MT_EVICT_SHARED: begin
            if (is_home) begin
              n_sh = sh_clr;
              if (sh_clr == 4'd0) begin
                n_ds = dmnc_pkg::DS_U;
              end else if ($onehot(sh_clr)) begin
                n_ds = dmnc_pkg::DS_EM;
                msgs_nxt[0] = dmnc_pkg::make_msg(dmnc_pkg::lowest_bit(sh_clr),
                  dmnc_pkg::MT_EVICT_SHARED, cur_r.addr, 8'd0, 4'd0, dmnc_pkg::NO_NODE,
                  dmnc_pkg::DS_EM);
                n = 3'd1;
              end else begin
                n_ds = dmnc_pkg::DS_S;
              end
            end
          end
          dmnc_pkg::MT_EVICT_MOD: begin
            if (is_home) begin
              n_sh  = sh_clr;
              n_ds  = dmnc_pkg::DS_U;
              n_mem = cur_r.value;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    cnt_nxt = n;
  end

  assign exec_en  = (state_r == dmnc_pkg::B_EXEC);
  assign out_fire = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmnc_pkg::B_IDLE: if (q_valid) state_nxt = dmnc_pkg::B_EXEC;
      dmnc_pkg::B_EXEC: state_nxt = (cnt_nxt == 3'd0) ? dmnc_pkg::B_IDLE : dmnc_pkg::B_EMIT;
      dmnc_pkg::B_EMIT: if (out_fire && out_last) state_nxt = dmnc_pkg::B_IDLE;
      default: state_nxt = dmnc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state_r == dmnc_pkg::B_IDLE);
    out_valid = (state_r == dmnc_pkg::B_EMIT);
    out_msg   = msgs_r[idx_r];
    out_last  = (idx_r == cnt_r - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dmnc_pkg::B_IDLE;
      idx_r     <= 3'd0;
      cnt_r     <= 3'd0;
      node_id_r <= 2'd0;
      await_r   <= 1'b0;
      pend_r    <= 8'd0;
      for (int i = 0; i < dmnc_pkg::CACHE_LINES; i++) begin
        line_tag_r[i]  <= dmnc_pkg::NO_TAG;
        line_data_r[i] <= 8'd0;
        line_st_r[i]   <= dmnc_pkg::LS_I;
      end
      for (int i = 0; i < dmnc_pkg::MEM_BLOCKS; i++) begin
        mem_r[i] <= 8'(i);
        dsh_r[i] <= 4'd0;
        dst_r[i] <= dmnc_pkg::DS_U;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        node_id_r <= cfg_wdata;
        for (int i = 0; i < dmnc_pkg::MEM_BLOCKS; i++) begin
          mem_r[i] <= dmnc_pkg::MEM_STEP * {6'd0, cfg_wdata} + 8'(i);
        end
      end else if (exec_en) begin
        mem_r[blk] <= n_mem;
      end
      if (exec_en) begin
        cnt_r           <= cnt_nxt;
        idx_r           <= 3'd0;
        await_r         <= await_nxt;
        pend_r          <= pend_nxt;
        line_tag_r[ci]  <= ln_tag;
        line_data_r[ci] <= ln_data;
        line_st_r[ci]   <= ln_st;
        dsh_r[blk]      <= n_sh;
        dst_r[blk]      <= n_ds;
      end else if (out_fire) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == dmnc_pkg::B_IDLE && q_valid) cur_r <= q_item;
    if (exec_en) begin
      for (int i = 0; i < dmnc_pkg::MAX_MSGS; i++) msgs_r[i] <= msgs_nxt[i];
    end
  end

endmodule

@@ src/directory_mesi_node_controller_core.sv @@
// Directory MESI node controller: a request waits in the front-end queue, then
// passes the back end's idle and execute states and, if it causes messages, the
// emit state, which sends them (up to 5) in order. Execute does the back end's
// read-modify-write of cache line and directory entry, one request at a time.
// Reset (rst_n low, synchronous) empties the queue, invalidates the cache,
// clears the directory to unowned and loads home memory with its start pattern.
module directory_mesi_node_controller_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [3:0]        in_msg_type,
  input  logic [1:0]        in_msg_sender,
  input  logic [5:0]        in_block_address,
  input  logic [7:0]        in_data_value,
  input  logic [3:0]        in_sharer_mask,
  input  logic signed [2:0] in_second_node,
  input  logic [1:0]        in_home_state,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_dest_node,
  output logic [3:0]        out_type,
  output logic [5:0]        out_address,
  output logic [7:0]        out_value,
  output logic [3:0]        out_sharers,
  output logic signed [2:0] out_second,
  output logic [1:0]        out_home_state,
  output logic              out_last
);

  // The front end classifies each request and drops those that cause nothing
  // (unused operation or message kinds). The rest wait in a two-entry queue,
  // so the front keeps taking requests while the back end is busy sending, until the queue is full.
  logic            q_valid;
  logic            q_ready;
  dmnc_pkg::item_t q_item;
  dmnc_pkg::msg_t  out_msg;

  dmnc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_msg_type      (in_msg_type),
    .in_msg_sender    (in_msg_sender),
    .in_block_address (in_block_address),
    .in_data_value    (in_data_value),
    .in_sharer_mask   (in_sharer_mask),
    .in_second_node   (in_second_node),
    .in_home_state    (in_home_state),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item)
  );

  // The back end loads one request, evaluates it against the cache line and
  // directory entry in its execute state, commits the updates and then sends
  // the buffered messages in order, marking the final one.
  dmnc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_msg   (out_msg),
    .out_last  (out_last)
  );

  assign out_dest_node  = out_msg.dest;
  assign out_type       = out_msg.mtype;
  assign out_address    = out_msg.addr;
  assign out_value      = out_msg.value;
  assign out_sharers    = out_msg.sharers;
  assign out_second     = out_msg.second;
  assign out_home_state = out_msg.hs;

endmodule

@@ src/dmnc_checker.sv @@
// Port-level checks of the node controller, bound to the top level.
// Depends on dmnc_pkg.
module dmnc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        out_type,
  input logic [3:0]        out_sharers,
  input logic [1:0]        out_home_state,
  input logic              out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_type) && $stable(out_last))
    else $error("result dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_type <= dmnc_pkg::MT_EVICT_MOD && out_home_state != 2'd3)
    else $error("unused message kind or directory state sent");

  a_sharers_only_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_type != dmnc_pkg::MT_REPLY_ID |-> out_sharers == 4'd0)
    else $error("sharer bits outside a reply with sharer ids");

endmodule

bind directory_mesi_node_controller_core dmnc_checker u_dmnc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_type       (out_type),
  .out_sharers    (out_sharers),
  .out_home_state (out_home_state),
  .out_last       (out_last)
);
